// ===== rtl/triangle_normal_and_area_top_defines.svh =====
// ----------------------------------------------------------------------------
// triangle normal and area: assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_AND_AREA_TOP_DEFINES_SVH
`define TRIANGLE_NORMAL_AND_AREA_TOP_DEFINES_SVH

// property checked at every edge, reset included
`define TNA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// property checked outside reset
`define TNA_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== rtl/tna_pkg.sv =====
// ----------------------------------------------------------------------------
// tna_pkg
// widths and packing constants for the triangle normal and area block
// ----------------------------------------------------------------------------
`default_nettype none
package tna_pkg;
   localparam int CoordW  = 16;
   localparam int DiffW   = 17;
   localparam int ProdW   = 34;
   localparam int SqSumW  = 34;
   localparam int SideW   = SqSumW / 2;
   localparam int PerimW  = SideW + 2;
   localparam int FactW   = PerimW + 1;
   localparam int HalfW   = 2 * PerimW;
   localparam int SplitW  = PerimW;
   localparam int HeronW  = 2 * HalfW;
   localparam int RootW   = HeronW / 2;
   localparam int NormW   = 34;
   localparam int AreaW   = 35;
   localparam int ReqDataW = 9 * CoordW;
   localparam int RspUsedW = 3 * NormW + AreaW;
   localparam int RspDataW = ((RspUsedW + 7) / 8) * 8;
endpackage
`default_nettype wire

// ===== rtl/tna_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// tna_isqrt_pipe
// pipelined floor square root, one root bit resolved per register stage
// ----------------------------------------------------------------------------
`default_nettype none
module tna_isqrt_pipe #(
   parameter int W = 34
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [W-1:0]     radicand,
   output logic      [W/2-1:0]   root
);
   localparam int R  = W / 2;
   localparam int RW = R + 3;

   logic [RW-1:0] rem_ff  [0:R-2];
   logic [R-1:0]  root_ff [0:R-1];
   logic [W-1:0]  rad_ff  [0:R-2];

   for (genvar k = 0; k < R; k++) begin : g_stage
      logic [RW-1:0] rem_cur;
      logic [R-1:0]  root_cur;
      logic [W-1:0]  rad_cur;
      logic [RW-1:0] shifted;
      logic [RW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = radicand;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign shifted = {rem_cur[RW-3:0], rad_cur[W-1:W-2]};
      assign trial   = {1'b0, root_cur, 2'b01};
      assign ge      = (shifted >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= {root_cur[R-2:0], ge};
         end
      end

      if (k < R - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? (shifted - trial) : shifted;
               rad_ff[k] <= {rad_cur[W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[R-1];
endmodule
`default_nettype wire

// ===== rtl/triangle_normal_and_area_top.sv =====
// each triangle flows through the 17-stage side root and 38-stage area root
//   pipelines (one bit a stage) on its way to the output register
// one triangle per cycle unless stalled; each stage takes a new item per cycle
// a stalled result freezes the whole pipeline in place, nothing lost or repeated
// reset (synchronous, active high) clears all valid bits; data is not reset
// ----------------------------------------------------------------------------
// triangle_normal_and_area_top
// cross product normal and heron area of one triangle per transfer
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_normal_and_area_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 16 bits each from bit 0
   input  wire logic [tna_pkg::ReqDataW-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // normal_x[33:0], normal_y[67:34], normal_z[101:68], tri_area[136:102], zero pad
   output logic [tna_pkg::RspDataW-1:0]     rsp_tdata
);
   localparam int CW  = tna_pkg::CoordW;
   localparam int DW  = tna_pkg::DiffW;
   localparam int PW  = tna_pkg::ProdW;
   localparam int QW  = tna_pkg::SqSumW;
   localparam int SW  = tna_pkg::SideW;
   localparam int PMW = tna_pkg::PerimW;
   localparam int FW  = tna_pkg::FactW;
   localparam int HW  = tna_pkg::HalfW;
   localparam int XW  = tna_pkg::SplitW;
   localparam int EW  = tna_pkg::HeronW;
   localparam int TW  = tna_pkg::RootW;
   localparam int NW  = tna_pkg::NormW;
   localparam int AW  = tna_pkg::AreaW;

   // stage map: 0 diffs, 1 products, 2 normals and squared sides,
   // 3..3+SW-1 side roots, then perimeter, factor products, partials, sum,
   // then TW area root stages
   localparam int NSTG = 3 + SW + 4 + TW;
   localparam int NL   = NSTG - 2;

   // the whole pipe moves whenever the output slot is free or being drained
   logic en;
   logic out_vld_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   logic vld_ff [0:NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) vld_ff[i] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < NSTG; i++) vld_ff[i] <= vld_ff[i-1];
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   // ---------------- stage 0: edge vectors ----------------
   logic signed [DW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   assign ax = DW'($signed(req_tdata[0*CW +: CW]));
   assign ay = DW'($signed(req_tdata[1*CW +: CW]));
   assign az = DW'($signed(req_tdata[2*CW +: CW]));
   assign bx = DW'($signed(req_tdata[3*CW +: CW]));
   assign by = DW'($signed(req_tdata[4*CW +: CW]));
   assign bz = DW'($signed(req_tdata[5*CW +: CW]));
   assign cx = DW'($signed(req_tdata[6*CW +: CW]));
   assign cy = DW'($signed(req_tdata[7*CW +: CW]));
   assign cz = DW'($signed(req_tdata[8*CW +: CW]));

   // e1 = a-b, e2 = a-c, e3 = b-c (c-a squares the same as e2)
   logic signed [DW-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff, x3_ff, y3_ff, z3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= ax - bx;  y1_ff <= ay - by;  z1_ff <= az - bz;
         x2_ff <= ax - cx;  y2_ff <= ay - cy;  z2_ff <= az - cz;
         x3_ff <= bx - cx;  y3_ff <= by - cy;  z3_ff <= bz - cz;
      end
   end

   // ---------------- stage 1: products ----------------
   logic signed [PW-1:0] pyz_ff, pzy_ff, pzx_ff, pxz_ff, pxy_ff, pyx_ff;
   logic signed [PW-1:0] q1x_ff, q1y_ff, q1z_ff, q2x_ff, q2y_ff, q2z_ff;
   logic signed [PW-1:0] q3x_ff, q3y_ff, q3z_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         pyz_ff <= y1_ff * z2_ff;  pzy_ff <= z1_ff * y2_ff;
         pzx_ff <= z1_ff * x2_ff;  pxz_ff <= x1_ff * z2_ff;
         pxy_ff <= x1_ff * y2_ff;  pyx_ff <= y1_ff * x2_ff;
         q1x_ff <= x1_ff * x1_ff;  q1y_ff <= y1_ff * y1_ff;  q1z_ff <= z1_ff * z1_ff;
         q2x_ff <= x2_ff * x2_ff;  q2y_ff <= y2_ff * y2_ff;  q2z_ff <= z2_ff * z2_ff;
         q3x_ff <= x3_ff * x3_ff;  q3y_ff <= y3_ff * y3_ff;  q3z_ff <= z3_ff * z3_ff;
      end
   end

   // ---------------- stage 2: normal and squared side lengths ----------------
   logic [3*NW-1:0] nrm_ff [0:NL-1];
   logic [3*NW-1:0] nrm_in;
   logic [QW-1:0]   sq1_ff, sq2_ff, sq3_ff;

   always_comb begin
      nrm_in[0*NW +: NW] = NW'(pyz_ff - pzy_ff);
      nrm_in[1*NW +: NW] = NW'(pzx_ff - pxz_ff);
      nrm_in[2*NW +: NW] = NW'(pxy_ff - pyx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nrm_ff[0] <= nrm_in;
         for (int i = 1; i < NL; i++) nrm_ff[i] <= nrm_ff[i-1];
         sq1_ff <= QW'(q1x_ff) + QW'(q1y_ff) + QW'(q1z_ff);
         sq2_ff <= QW'(q3x_ff) + QW'(q3y_ff) + QW'(q3z_ff);
         sq3_ff <= QW'(q2x_ff) + QW'(q2y_ff) + QW'(q2z_ff);
      end
   end

   // ---------------- side length roots ----------------
   logic [SW-1:0] s1, s2, s3;

   tna_isqrt_pipe #(.W(QW)) u_side1 (.clock(clock), .en(en), .radicand(sq1_ff), .root(s1));
   tna_isqrt_pipe #(.W(QW)) u_side2 (.clock(clock), .en(en), .radicand(sq2_ff), .root(s2));
   tna_isqrt_pipe #(.W(QW)) u_side3 (.clock(clock), .en(en), .radicand(sq3_ff), .root(s3));

   // ---------------- perimeter and heron factors ----------------
   logic [PMW-1:0]       perim_in;
   logic signed [FW-1:0] f1_in, f2_in, f3_in;
   logic [PMW-1:0]       perim_ff, f1_ff, f2_ff, f3_ff;
   logic                 fok_ff;

   always_comb begin
      perim_in = PMW'(s1) + PMW'(s2) + PMW'(s3);
      f1_in    = $signed({1'b0, perim_in}) - $signed(FW'({s1, 1'b0}));
      f2_in    = $signed({1'b0, perim_in}) - $signed(FW'({s2, 1'b0}));
      f3_in    = $signed({1'b0, perim_in}) - $signed(FW'({s3, 1'b0}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         perim_ff <= perim_in;
         f1_ff    <= f1_in[PMW-1:0];
         f2_ff    <= f2_in[PMW-1:0];
         f3_ff    <= f3_in[PMW-1:0];
         // a negative factor from side rounding clamps the area to zero
         fok_ff   <= !f1_in[FW-1] && !f2_in[FW-1] && !f3_in[FW-1];
      end
   end

   // ---------------- factor pair products ----------------
   logic [HW-1:0] u_ff, v_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= fok_ff ? (HW'(perim_ff) * HW'(f1_ff)) : '0;
         v_ff <= HW'(f2_ff) * HW'(f3_ff);
      end
   end

   // ---------------- wide product as four partials ----------------
   logic [2*XW-1:0] pp_hh_ff, pp_hl_ff, pp_lh_ff, pp_ll_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         pp_hh_ff <= (2*XW)'(u_ff[HW-1:XW]) * (2*XW)'(v_ff[HW-1:XW]);
         pp_hl_ff <= (2*XW)'(u_ff[HW-1:XW]) * (2*XW)'(v_ff[XW-1:0]);
         pp_lh_ff <= (2*XW)'(u_ff[XW-1:0])  * (2*XW)'(v_ff[HW-1:XW]);
         pp_ll_ff <= (2*XW)'(u_ff[XW-1:0])  * (2*XW)'(v_ff[XW-1:0]);
      end
   end

   logic [EW-1:0] heron_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         heron_ff <= (EW'(pp_hh_ff) << (2*XW))
                   + ((EW'(pp_hl_ff) + EW'(pp_lh_ff)) << XW)
                   + EW'(pp_ll_ff);
      end
   end

   // ---------------- area root ----------------
   logic [TW-1:0] area_root;
   tna_isqrt_pipe #(.W(EW)) u_area (.clock(clock), .en(en), .radicand(heron_ff),
                                   .root(area_root));

   // ---------------- output register ----------------
   logic [tna_pkg::RspDataW-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {(tna_pkg::RspDataW - tna_pkg::RspUsedW)'(0),
                         area_root[AW+1:2],
                         nrm_ff[NL-1]};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

// ===== rtl/tna_port_checker.sv =====
// ----------------------------------------------------------------------------
// tna_port_checker
// port level checks on the triangle normal and area block
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_normal_and_area_top_defines.svh"
module tna_port_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tvalid,
   input wire logic                         req_tready,
   input wire logic [tna_pkg::ReqDataW-1:0] req_tdata,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [tna_pkg::RspDataW-1:0] rsp_tdata
);
   `TNA_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")
   `TNA_ASSERT_RUN(a_stall_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `TNA_ASSERT_RUN(a_pad_zero, rsp_tvalid |-> rsp_tdata[tna_pkg::RspDataW-1:tna_pkg::RspUsedW] == '0, "pad bits set")
   `TNA_ASSERT_RUN(a_free_ready, !rsp_tvalid |-> req_tready, "input blocked with free output")
   `TNA_ASSERT_RUN(a_stall_blocks, rsp_tvalid && !rsp_tready |-> !req_tready && !(req_tvalid && req_tready && req_tdata != req_tdata), "input taken while stalled")
endmodule

bind triangle_normal_and_area_top tna_port_checker u_tna_port_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
